>>> hw/rtl/tgcd_pkg.sv
// Shared types, constants and the arctangent table of the trip distance unit.
package tgcd_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 20;
    localparam int CORDIC_STAGES_DEF   = 24;

    localparam int LAT_W  = 28;
    localparam int LON_W  = 29;
    localparam int RAD_W  = 21;
    localparam int LEG_W  = 23;
    localparam int TOT_W  = 32;
    localparam int CD_W   = 34;   // CORDIC datapath width
    localparam int MUL_W  = 33;   // signed multiplier operand width
    localparam int CNT_W  = 5;    // iteration counter, up to 32 steps
    localparam int SQRT_STEPS = 31;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 21'd1630976;
    localparam logic [31:0]      DEG_TO_TURN  = 32'd3054198966;
    localparam logic [31:0]      PI_Q30       = 32'd3373259426;
    localparam logic [31:0]      CORDIC_ONE   = 32'd652032874;
    localparam logic [30:0]      Q30_ONE      = 31'd1073741824;

    typedef enum logic [4:0] {
        S_IDLE, S_CV_MUL, S_CV_FIN, S_SC_INIT, S_SC_STEP, S_SC_FIN,
        S_MP_MUL, S_MP_FIN, S_SUM_A, S_SQ_INIT, S_SQ_STEP, S_SQ_FIN,
        S_AT_INIT, S_AT_STEP, S_AT_FIN, S_RC_MUL, S_RC_FIN, S_TOTAL
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_CV_MUL, OP_CV_FIN, OP_SC_INIT, OP_SC_STEP,
        OP_SC_FIN, OP_MP_MUL, OP_MP_FIN, OP_SUM_A, OP_SQ_INIT, OP_SQ_STEP,
        OP_SQ_FIN, OP_AT_INIT, OP_AT_STEP, OP_AT_FIN, OP_RC_MUL, OP_RC_FIN,
        OP_TOTAL
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [1:0]       sel;
        logic [CNT_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic out_free;
    } t_stat;

    // arctan(2^-i) in 2^-32 turns
    function automatic logic [29:0] atan_turns(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/trip_great_circle_distance_unit.sv
// Top level of the trip great-circle distance unit.
// Input channel (i_valid / o_ready): one beat is one waypoint, latitude and
// longitude in degrees with ANGLE_FRAC_BITS fraction bits, plus a last-point mark.
// Output channel (o_valid / i_ready): one beat per waypoint with the leg, the
// running total (1/256 km, saturating), trip-done and saturation flags.
// i_cfg_we / i_cfg_data write the sphere radius; write it only while idle.
// One waypoint is worked at a time by a shared multiplier, one iterative CORDIC
// unit and a one-digit-per-cycle square root. For a waypoint with a previous
// point four sine/cosine passes, two 31-step roots and one atan2 pass dominate
// the work; the first waypoint of a trip skips them. o_ready is high while the
// sequencer is idle. The next waypoint is accepted while the previous result
// still sits in the output register.
// If the receiver stalls, the finished result holds in the output register and
// the next waypoint waits at its final step until that register frees.
// Reset (i_rst_n low, synchronous) clears the trip, drops any pending result
// and loads the radius with 6371 km.
module trip_great_circle_distance_unit #(
    parameter int ANGLE_FRAC_BITS = tgcd_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = tgcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tgcd_pkg::RAD_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [tgcd_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [tgcd_pkg::LON_W-1:0] i_longitude,
    input  logic                              i_last_point,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tgcd_pkg::LEG_W-1:0]        o_leg_distance,
    output logic [tgcd_pkg::TOT_W-1:0]        o_total_distance,
    output logic                              o_trip_done,
    output logic                              o_total_saturated
);
    import tgcd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    tgcd_ctrl #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // arithmetic and trip state
    tgcd_datapath #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_latitude        (i_latitude),
        .i_longitude       (i_longitude),
        .i_last_point      (i_last_point),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_leg_distance    (o_leg_distance),
        .o_total_distance  (o_total_distance),
        .o_trip_done       (o_trip_done),
        .o_total_saturated (o_total_saturated)
    );

    // an accepted waypoint keeps the sequencer busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on two consecutive cycles");

    // a saturated total reads full scale
    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_total_saturated) |-> (o_total_distance == '1))
        else $error("saturation flag set with total below full scale");

    // CORDIC iteration index stays inside the stage count
    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_cmd.op == OP_SC_STEP) || (w_cmd.op == OP_AT_STEP))
        |-> (w_cmd.iter <= CNT_W'(CORDIC_STAGES - 1)))
        else $error("CORDIC iteration beyond last stage");

endmodule

>>> hw/rtl/tgcd_ctrl.sv
// Sequencer of the trip distance unit: steps the datapath through one waypoint.
module tgcd_ctrl #(
    parameter int CORDIC_STAGES = tgcd_pkg::CORDIC_STAGES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tgcd_pkg::t_stat i_stat,
    output tgcd_pkg::t_cmd  o_cmd
);
    import tgcd_pkg::*;

    localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STAGES - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(SQRT_STEPS - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_sel, n_sel;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // advance state, operand select and iteration count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 2'd0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CV_MUL;
                    n_sel   = 2'd0;
                end
            end
            S_CV_MUL: n_state = S_CV_FIN;
            S_CV_FIN: begin
                if (r_sel == 2'd0) begin
                    n_state = S_CV_MUL;
                    n_sel   = 2'd1;
                end else if (i_stat.have_prev) begin
                    n_state = S_SC_INIT;
                    n_sel   = 2'd0;
                end else begin
                    n_state = S_TOTAL;
                end
            end
            S_SC_INIT: begin
                n_state = S_SC_STEP;
                n_cnt   = '0;
            end
            S_SC_STEP: begin
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_SC_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SC_FIN: begin
                if (r_sel == 2'd3) begin
                    n_state = S_MP_MUL;
                    n_sel   = 2'd0;
                end else begin
                    n_state = S_SC_INIT;
                    n_sel   = r_sel + 1'b1;
                end
            end
            S_MP_MUL: n_state = S_MP_FIN;
            S_MP_FIN: begin
                if (r_sel == 2'd3) begin
                    n_state = S_SUM_A;
                end else begin
                    n_state = S_MP_MUL;
                    n_sel   = r_sel + 1'b1;
                end
            end
            S_SUM_A: begin
                n_state = S_SQ_INIT;
                n_sel   = 2'd0;
            end
            S_SQ_INIT: begin
                n_state = S_SQ_STEP;
                n_cnt   = '0;
            end
            S_SQ_STEP: begin
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_SQ_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQ_FIN: begin
                if (r_sel == 2'd1) begin
                    n_state = S_AT_INIT;
                end else begin
                    n_state = S_SQ_INIT;
                    n_sel   = 2'd1;
                end
            end
            S_AT_INIT: begin
                n_state = S_AT_STEP;
                n_cnt   = '0;
            end
            S_AT_STEP: begin
                if (r_cnt == CORDIC_LAST) begin
                    n_state = S_AT_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_AT_FIN: begin
                n_state = S_RC_MUL;
                n_sel   = 2'd0;
            end
            S_RC_MUL: n_state = S_RC_FIN;
            S_RC_FIN: begin
                if (r_sel == 2'd1) begin
                    n_state = S_TOTAL;
                end else begin
                    n_state = S_RC_MUL;
                    n_sel   = 2'd1;
                end
            end
            S_TOTAL: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_ready    = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.sel  = r_sel;
        o_cmd.iter = r_cnt;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                end
            end
            S_CV_MUL:  o_cmd.op = OP_CV_MUL;
            S_CV_FIN:  o_cmd.op = OP_CV_FIN;
            S_SC_INIT: o_cmd.op = OP_SC_INIT;
            S_SC_STEP: o_cmd.op = OP_SC_STEP;
            S_SC_FIN:  o_cmd.op = OP_SC_FIN;
            S_MP_MUL:  o_cmd.op = OP_MP_MUL;
            S_MP_FIN:  o_cmd.op = OP_MP_FIN;
            S_SUM_A:   o_cmd.op = OP_SUM_A;
            S_SQ_INIT: o_cmd.op = OP_SQ_INIT;
            S_SQ_STEP: o_cmd.op = OP_SQ_STEP;
            S_SQ_FIN:  o_cmd.op = OP_SQ_FIN;
            S_AT_INIT: o_cmd.op = OP_AT_INIT;
            S_AT_STEP: o_cmd.op = OP_AT_STEP;
            S_AT_FIN:  o_cmd.op = OP_AT_FIN;
            S_RC_MUL:  o_cmd.op = OP_RC_MUL;
            S_RC_FIN:  o_cmd.op = OP_RC_FIN;
            S_TOTAL: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_TOTAL;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/tgcd_datapath.sv
// Datapath of the trip distance unit: multiplier, CORDIC, square root, trip state.
module tgcd_datapath #(
    parameter int ANGLE_FRAC_BITS = tgcd_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tgcd_pkg::RAD_W-1:0]          i_cfg_data,
    input  logic signed [tgcd_pkg::LAT_W-1:0]   i_latitude,
    input  logic signed [tgcd_pkg::LON_W-1:0]   i_longitude,
    input  logic                                i_last_point,
    input  tgcd_pkg::t_cmd                      i_cmd,
    output tgcd_pkg::t_stat                     o_stat,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [tgcd_pkg::LEG_W-1:0]          o_leg_distance,
    output logic [tgcd_pkg::TOT_W-1:0]          o_total_distance,
    output logic                                o_trip_done,
    output logic                                o_total_saturated
);
    import tgcd_pkg::*;

    localparam int CV_SHIFT = ANGLE_FRAC_BITS + 8;

    // configuration and input beat
    logic [RAD_W-1:0]        r_radius;
    logic signed [LAT_W-1:0] r_lat;
    logic signed [LON_W-1:0] r_lon;
    logic                    r_last;

    // trip state, angles in 2^-32 turns
    logic [31:0]      r_cur_lat_t, r_cur_lon_t, r_prev_lat_t, r_prev_lon_t;
    logic             r_have_prev;
    logic [TOT_W-1:0] r_total;
    logic             r_sat;

    // working registers
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [CD_W-1:0]    r_cx, r_cy, r_cz;
    logic                      r_flip;
    logic signed [MUL_W-1:0]   r_sa, r_sb, r_c1, r_c2, r_pa, r_pb, r_pc;
    logic [30:0]               r_a, r_root, r_ys, r_xs, r_z;
    logic [61:0]               r_rad;
    logic [32:0]               r_rem;
    logic [31:0]               r_crad;
    logic [LEG_W-1:0]          r_leg;

    // output register
    logic             r_out_valid;
    logic [LEG_W-1:0] r_o_leg;
    logic [TOT_W-1:0] r_o_total;
    logic             r_o_done, r_o_sat;

    logic [LAT_W-1:0]          lat_mag;
    logic [LON_W-1:0]          lon_mag;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    logic [2*MUL_W-1:0]        cv_sum, cv_sh, rc_sum;
    logic [31:0]               cv_t, cv_turn;
    logic [31:0]               d_ang, sc_ang, sc_ang_rot;
    logic                      sc_flip;
    logic signed [CD_W-1:0]    dx, dy, atn;
    logic signed [CD_W-1:0]    sc_x, sc_y;
    logic signed [CD_W:0]      a_sum;
    logic [34:0]               sq_trial, sq_div;
    logic [LEG_W-1:0]          leg_eff;
    logic [TOT_W:0]            tot_sum;

    // magnitudes of the captured angles
    assign lat_mag = r_lat[LAT_W-1] ? LAT_W'(-r_lat) : r_lat;
    assign lon_mag = r_lon[LON_W-1] ? LON_W'(-r_lon) : r_lon;

    // select multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_CV_MUL: begin
                mul_a = (i_cmd.sel == 2'd0) ? $signed(MUL_W'(lat_mag))
                                            : $signed(MUL_W'(lon_mag));
                mul_b = $signed({1'b0, DEG_TO_TURN});
            end
            OP_MP_MUL: begin
                case (i_cmd.sel)
                    2'd0: begin mul_a = r_sa; mul_b = r_sa; end
                    2'd1: begin mul_a = r_sb; mul_b = r_sb; end
                    2'd2: begin mul_a = r_c1; mul_b = r_c2; end
                    default: begin mul_a = r_pc; mul_b = r_pb; end
                endcase
            end
            OP_RC_MUL: begin
                if (i_cmd.sel == 2'd0) begin
                    mul_a = $signed(MUL_W'(r_z));
                    mul_b = $signed({1'b0, PI_Q30});
                end else begin
                    mul_a = $signed(MUL_W'(r_radius));
                    mul_b = $signed({1'b0, r_crad});
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round degrees to turns, symmetric about zero
    assign cv_sum  = $unsigned(r_prod) + ((2*MUL_W)'(1) << (CV_SHIFT - 1));
    assign cv_sh   = cv_sum >> CV_SHIFT;
    assign cv_t    = cv_sh[31:0];
    assign cv_turn = ((i_cmd.sel == 2'd0) ? r_lat[LAT_W-1] : r_lon[LON_W-1])
                     ? (32'd0 - cv_t) : cv_t;

    // pick the sine/cosine angle, fold the left half-plane by half a turn
    always_comb begin
        d_ang = 32'd0;
        case (i_cmd.sel)
            2'd0: begin
                d_ang  = r_cur_lat_t - r_prev_lat_t;
                sc_ang = {d_ang[31], d_ang[31:1]};
            end
            2'd1: begin
                d_ang  = r_cur_lon_t - r_prev_lon_t;
                sc_ang = {d_ang[31], d_ang[31:1]};
            end
            2'd2:    sc_ang = r_prev_lat_t;
            default: sc_ang = r_cur_lat_t;
        endcase
    end

    assign sc_flip    = sc_ang[31] ^ sc_ang[30];
    assign sc_ang_rot = {sc_ang[31] ^ sc_flip, sc_ang[30:0]};

    // one CORDIC micro-rotation
    assign dx  = r_cy >>> i_cmd.iter;
    assign dy  = r_cx >>> i_cmd.iter;
    assign atn = $signed(CD_W'(atan_turns(i_cmd.iter)));

    assign sc_x = r_flip ? -r_cx : r_cx;
    assign sc_y = r_flip ? -r_cy : r_cy;

    // haversine term before clamping
    assign a_sum = (CD_W+1)'(r_pa) + (CD_W+1)'(r_pb);

    // one root digit
    assign sq_trial = {r_rem, r_rad[61:60]};
    assign sq_div   = {2'b00, r_root, 2'b01};

    // rounding of the scaled products
    assign rc_sum = $unsigned(r_prod) + ((2*MUL_W)'(1) << 29);

    // leg and saturating total
    assign leg_eff = r_have_prev ? r_leg : '0;
    assign tot_sum = (TOT_W+1)'(r_total) + (TOT_W+1)'(leg_eff);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_RESET;
            r_have_prev  <= 1'b0;
            r_total      <= '0;
            r_sat        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_lat_t <= '0;
            r_prev_lon_t <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_data;
            end
            if (i_cmd.op == OP_TOTAL) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_have_prev  <= 1'b0;
                    r_total      <= '0;
                    r_sat        <= 1'b0;
                    r_prev_lat_t <= '0;
                    r_prev_lon_t <= '0;
                end else begin
                    r_have_prev  <= 1'b1;
                    r_total      <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                    r_sat        <= r_sat | tot_sum[TOT_W];
                    r_prev_lat_t <= r_cur_lat_t;
                    r_prev_lon_t <= r_cur_lon_t;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_lat  <= i_latitude;
                r_lon  <= i_longitude;
                r_last <= i_last_point;
            end
            OP_CV_MUL, OP_MP_MUL, OP_RC_MUL: r_prod <= mul_p;
            OP_CV_FIN: begin
                if (i_cmd.sel == 2'd0) begin
                    r_cur_lat_t <= cv_turn;
                end else begin
                    r_cur_lon_t <= cv_turn;
                end
            end
            OP_SC_INIT: begin
                r_cx   <= $signed(CD_W'(CORDIC_ONE));
                r_cy   <= '0;
                r_cz   <= CD_W'($signed(sc_ang_rot));
                r_flip <= sc_flip;
            end
            OP_SC_STEP: begin
                if (!r_cz[CD_W-1]) begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_cz <= r_cz - atn;
                end else begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_cz <= r_cz + atn;
                end
            end
            OP_SC_FIN: begin
                case (i_cmd.sel)
                    2'd0:    r_sa <= MUL_W'(sc_y);
                    2'd1:    r_sb <= MUL_W'(sc_y);
                    2'd2:    r_c1 <= MUL_W'(sc_x);
                    default: r_c2 <= MUL_W'(sc_x);
                endcase
            end
            OP_MP_FIN: begin
                case (i_cmd.sel)
                    2'd0:    r_pa <= $signed(r_prod[62:30]);
                    2'd2:    r_pc <= $signed(r_prod[62:30]);
                    default: r_pb <= $signed(r_prod[62:30]);
                endcase
            end
            OP_SUM_A: begin
                if (a_sum[CD_W]) begin
                    r_a <= '0;
                end else if (a_sum > (CD_W+1)'(Q30_ONE)) begin
                    r_a <= Q30_ONE;
                end else begin
                    r_a <= a_sum[30:0];
                end
            end
            OP_SQ_INIT: begin
                r_rad  <= (i_cmd.sel == 2'd0) ? {1'b0, r_a, 30'd0}
                                              : {1'b0, Q30_ONE - r_a, 30'd0};
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQ_STEP: begin
                r_rad <= {r_rad[59:0], 2'b00};
                if (sq_trial >= sq_div) begin
                    r_rem  <= 33'(sq_trial - sq_div);
                    r_root <= {r_root[29:0], 1'b1};
                end else begin
                    r_rem  <= sq_trial[32:0];
                    r_root <= {r_root[29:0], 1'b0};
                end
            end
            OP_SQ_FIN: begin
                if (i_cmd.sel == 2'd0) begin
                    r_ys <= r_root;
                end else begin
                    r_xs <= r_root;
                end
            end
            OP_AT_INIT: begin
                r_cx <= $signed(CD_W'(r_xs));
                r_cy <= $signed(CD_W'(r_ys));
                r_cz <= '0;
            end
            OP_AT_STEP: begin
                if (!r_cy[CD_W-1]) begin
                    r_cx <= r_cx + dx;
                    r_cy <= r_cy - dy;
                    r_cz <= r_cz + atn;
                end else begin
                    r_cx <= r_cx - dx;
                    r_cy <= r_cy + dy;
                    r_cz <= r_cz - atn;
                end
            end
            OP_AT_FIN: begin
                if (r_cz[CD_W-1]) begin
                    r_z <= '0;
                end else if (r_cz > $signed(CD_W'(Q30_ONE))) begin
                    r_z <= Q30_ONE;
                end else begin
                    r_z <= r_cz[30:0];
                end
            end
            OP_RC_FIN: begin
                if (i_cmd.sel == 2'd0) begin
                    r_crad <= rc_sum[61:30];
                end else begin
                    r_leg <= rc_sum[LEG_W+29:30];
                end
            end
            OP_TOTAL: begin
                r_o_leg   <= leg_eff;
                r_o_total <= tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                r_o_done  <= r_last;
                r_o_sat   <= r_sat | tot_sum[TOT_W];
            end
            default: begin
            end
        endcase
    end

    assign o_stat.have_prev  = r_have_prev;
    assign o_stat.out_free   = !r_out_valid || i_ready;
    assign o_valid           = r_out_valid;
    assign o_leg_distance    = r_o_leg;
    assign o_total_distance  = r_o_total;
    assign o_trip_done       = r_o_done;
    assign o_total_saturated = r_o_sat;

endmodule

>>> tb/sv/trip_great_circle_distance_unit_checker.sv
// Checker for the trip distance unit: predicts each leg and compares result beats.
`timescale 1ns / 100ps
module trip_great_circle_distance_unit_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tgcd_pkg::RAD_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    input  logic                              i_in_ready,
    input  logic signed [tgcd_pkg::LAT_W-1:0] i_latitude,
    input  logic signed [tgcd_pkg::LON_W-1:0] i_longitude,
    input  logic                              i_last_point,
    input  logic                              i_out_valid,
    input  logic                              i_ready,
    input  logic [tgcd_pkg::LEG_W-1:0]        i_leg_distance,
    input  logic [tgcd_pkg::TOT_W-1:0]        i_total_distance,
    input  logic                              i_trip_done,
    input  logic                              i_total_saturated,
    output int                                o_fail_count,
    output int                                o_pending
);
    import tgcd_pkg::*;

    localparam int FRAC   = 20;
    localparam int STAGES = 24;

    typedef struct {
        logic [LEG_W-1:0] leg;
        logic [TOT_W-1:0] total;
        logic             done;
        logic             sat;
    } leg_result_t;

    // arctan(2^-i) in 2^-32 turns
    localparam longint ARCTAN_TURNS [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    leg_result_t        expected_legs[$];
    logic [RAD_W-1:0]   radius;
    logic signed [LAT_W-1:0] prev_lat;
    logic signed [LON_W-1:0] prev_lon;
    logic               have_prev;
    logic [TOT_W-1:0]   trip_total;
    logic               trip_sat;
    int                 mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_legs.size();

    function automatic logic [31:0] deg_to_turns(input longint d);
        longint unsigned mag;
        longint unsigned p;
        logic [31:0]     t;
        mag = (d < 0) ? -d : d;
        p = (mag * 64'd3054198966 + (64'd1 << (FRAC + 7))) >> (FRAC + 8);
        t = p[31:0];
        return (d < 0) ? 32'd0 - t : t;
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output longint s, output longint c);
        logic   flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        int     zi;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip) ang = ang + 32'h8000_0000;
        zi = ang;
        z = zi;
        x = 652032874;
        y = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ARCTAN_TURNS[i];
            end else begin
                x += dx; y -= dy; z += ARCTAN_TURNS[i];
            end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    function automatic longint vector_atan(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ARCTAN_TURNS[i];
            end else begin
                x -= dx; y += dy; z -= ARCTAN_TURNS[i];
            end
        end
        if (z < 0) z = 0;
        if (z > 64'd1073741824) z = 64'd1073741824;
        return z;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint q30_mul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    task automatic haversine_leg(input longint lat1, input longint lon1,
                                 input longint lat2, input longint lon2,
                                 output logic [31:0] leg);
        logic [31:0]     p1, p2, l1, l2, dp, dl;
        longint          sa, sb, c1, c2, unused, a, z;
        longint unsigned ys, xs, crad, scaled;
        p1 = deg_to_turns(lat1);
        p2 = deg_to_turns(lat2);
        l1 = deg_to_turns(lon1);
        l2 = deg_to_turns(lon2);
        dp = p2 - p1;
        dl = l2 - l1;
        sin_cos({dp[31], dp[31:1]}, sa, unused);
        sin_cos({dl[31], dl[31:1]}, sb, unused);
        sin_cos(p1, unused, c1);
        sin_cos(p2, unused, c2);
        a = q30_mul(sa, sa) + q30_mul(q30_mul(c1, c2), q30_mul(sb, sb));
        if (a < 0) a = 0;
        if (a > 64'd1073741824) a = 64'd1073741824;
        ys = floor_sqrt(longint'(a) << 30);
        xs = floor_sqrt((64'd1073741824 - a) << 30);
        z = vector_atan(ys, xs);
        crad = (z * 64'd3373259426 + (64'd1 << 29)) >> 30;
        scaled = (longint'(radius) * crad + (64'd1 << 29)) >> 30;
        leg = scaled[31:0];
    endtask

    // Predict the result of one accepted waypoint and advance the trip state.
    task automatic accept_waypoint(input logic signed [LAT_W-1:0] lat,
                                   input logic signed [LON_W-1:0] lon, input logic last);
        logic [31:0] leg;
        logic [32:0] sum;
        leg_result_t r;
        leg = 0;
        if (have_prev) haversine_leg(prev_lat, prev_lon, lat, lon, leg);
        sum = trip_total + leg;
        if (sum[32]) begin
            sum = 33'hFFFF_FFFF;
            trip_sat = 1'b1;
        end
        trip_total = sum[31:0];
        r.leg   = leg[LEG_W-1:0];
        r.total = trip_total;
        r.done  = last;
        r.sat   = trip_sat;
        expected_legs = {expected_legs, r};
        if (last) begin
            prev_lat = 0; prev_lon = 0; have_prev = 0; trip_total = 0; trip_sat = 0;
        end else begin
            prev_lat = lat; prev_lon = lon; have_prev = 1;
        end
    endtask

    initial mismatches = 0;

    always @(posedge i_clk) begin
        leg_result_t e;
        if (!i_rst_n) begin
            radius = RADIUS_RESET;
            prev_lat = 0; prev_lon = 0; have_prev = 0; trip_total = 0; trip_sat = 0;
            expected_legs.delete();
        end else begin
            if (i_cfg_we) radius = i_cfg_data;
            // Compare the result beat with the oldest prediction
            if (i_out_valid && i_ready) begin
                if (expected_legs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: leg %0d total %0d",
                                 i_leg_distance, i_total_distance);
                end else begin
                    e = expected_legs.pop_front();
                    if (i_leg_distance !== e.leg || i_total_distance !== e.total ||
                        i_trip_done !== e.done || i_total_saturated !== e.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: leg %0d/%0d total %0d/%0d ",
                                      "done %0b/%0b sat %0b/%0b (exp/act)"},
                                     e.leg, i_leg_distance, e.total, i_total_distance,
                                     e.done, i_trip_done, e.sat, i_total_saturated);
                    end
                end
            end
            if (i_valid && i_in_ready) accept_waypoint(i_latitude, i_longitude, i_last_point);
        end
    end
endmodule

>>> tb/sv/trip_great_circle_distance_unit_test.sv
// Top of the trip distance unit testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module trip_great_circle_distance_unit_test;
    import tgcd_pkg::*;

    localparam int LAT_MAX   = 94371840;
    localparam int LON_MAX   = 188743680;
    localparam int IDLE_MAX  = 10000;
    localparam int TAIL_WAIT = 300;
    localparam int SAT_HOPS  = 656;

    logic                     i_clk = 0;
    logic                     i_rst_n = 0;
    logic                     i_cfg_we = 0;
    logic [RAD_W-1:0]         i_cfg_data = '0;
    logic                     i_valid = 0;
    logic                     o_ready;
    logic signed [LAT_W-1:0]  i_latitude = '0;
    logic signed [LON_W-1:0]  i_longitude = '0;
    logic                     i_last_point = 0;
    logic                     o_valid;
    logic                     i_ready = 0;
    logic [LEG_W-1:0]         o_leg_distance;
    logic [TOT_W-1:0]         o_total_distance;
    logic                     o_trip_done;
    logic                     o_total_saturated;
    int                       fail_count;
    int                       pending;
    int                       quiet_cycles = 0;
    int                       stall_left = 0;
    logic                     steady_mode = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    trip_great_circle_distance_unit dut (.*);

    trip_great_circle_distance_unit_checker leg_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .i_in_ready(o_ready),
        .i_latitude, .i_longitude, .i_last_point, .i_out_valid(o_valid), .i_ready,
        .i_leg_distance(o_leg_distance), .i_total_distance(o_total_distance),
        .i_trip_done(o_trip_done), .i_total_saturated(o_total_saturated),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: draw a stall before each result beat, none in steady mode
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                stall_left = steady_mode ? 0 : $urandom_range(0, 14);
                if (stall_left > 0) i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0) i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= IDLE_MAX) begin
            $display("trip_great_circle_distance_unit test failed");
            $finish;
        end
    end

    // Drive one waypoint beat after a random gap (none in steady mode) and hold until accepted
    task automatic send_waypoint(input int lat, input int lon, input logic last);
        int gap;
        gap = steady_mode ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_latitude   <= LAT_W'(lat);
        i_longitude  <= LON_W'(lon);
        i_last_point <= last;
        forever begin
            @(negedge i_clk);
            if (o_ready) break;
        end
        @(posedge i_clk);
    endtask

    // Drain all results, then write the radius while idle
    task automatic set_radius(input logic [RAD_W-1:0] r);
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int rand_lat(input bit full);
        if (full) return $signed(LAT_W'($urandom));
        return $urandom_range(0, 2 * LAT_MAX) - LAT_MAX;
    endfunction

    function automatic int rand_lon(input bit full);
        if (full) return $signed(LON_W'($urandom));
        return $urandom_range(0, 2 * LON_MAX) - LON_MAX;
    endfunction

    // Random trips of random length; a share of raw out-of-range angles
    task automatic random_trips(input int count);
        int  sent;
        int  len;
        bit  full;
        sent = 0;
        while (sent < count) begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
            if ($urandom_range(0, 7) == 0) steady_mode = ~steady_mode;
            for (int k = 0; k < len; k++) begin
                full = ($urandom_range(0, 4) == 0);
                send_waypoint(rand_lat(full), rand_lon(full), k == len - 1);
                sent++;
            end
        end
        steady_mode = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pole to pole, date line, raw extremes, one-point trip
        send_waypoint(0, 0, 0);
        send_waypoint(LAT_MAX, 0, 0);
        send_waypoint(-LAT_MAX, 0, 0);
        send_waypoint(0, LON_MAX, 0);
        send_waypoint(0, -LON_MAX, 0);
        send_waypoint(LAT_MAX, LON_MAX, 0);
        send_waypoint(LAT_MAX, LON_MAX, 0);
        send_waypoint((1 << 27) - 1, (1 << 28) - 1, 0);
        send_waypoint(-(1 << 27), -(1 << 28), 0);
        send_waypoint(-1, 1, 0);
        send_waypoint(1, -1, 1);
        send_waypoint(12345, -67890, 1);
        send_waypoint(-LAT_MAX, -LON_MAX, 0);
        send_waypoint(LAT_MAX, LON_MAX, 1);

        set_radius(1);
        send_waypoint(0, 0, 0);
        send_waypoint(0, LON_MAX, 0);
        send_waypoint(LAT_MAX, -LON_MAX, 1);

        set_radius(21'h1F_FFFF);
        send_waypoint(-LAT_MAX, 0, 0);
        send_waypoint(LAT_MAX, 0, 1);

        // Saturate the total with antipodal hops, then close the trip
        steady_mode = 1;
        for (int k = 0; k < SAT_HOPS; k++)
            send_waypoint(0, (k % 2) ? LON_MAX : 0, k == SAT_HOPS - 1);
        steady_mode = 0;

        set_radius(RADIUS_RESET);
        random_trips(20);

        set_radius(RAD_W'($urandom_range(1, 2097151)));
        random_trips(15);

        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("trip_great_circle_distance_unit test passed");
        else
            $display("trip_great_circle_distance_unit test failed");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/tgcd_pkg.sv
hw/rtl/tgcd_ctrl.sv
hw/rtl/tgcd_datapath.sv
hw/rtl/trip_great_circle_distance_unit.sv
tb/sv/trip_great_circle_distance_unit_checker.sv
tb/sv/trip_great_circle_distance_unit_test.sv
